/* src/lcdt_pkg.sv */
// shared types, constants and mode codes for the lcd mode and line timing core
`default_nettype none

package lcdt_pkg;

  localparam int unsigned DOTS_PER_LINE_DEF   = 456;
  localparam int unsigned VISIBLE_LINES_DEF   = 144;
  localparam int unsigned LINES_PER_FRAME_DEF = 154;

  localparam int unsigned DOT_W  = 9;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned ADV_W  = 8;
  localparam int unsigned MODE_W = 2;

  localparam logic [DOT_W-1:0] OAM_END_DOT  = DOT_W'(80);
  localparam logic [DOT_W-1:0] XFER_END_DOT = DOT_W'(80 + 172);

  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_XFER   = 2'd3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HBLANK_IRQ_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VBLANK_IRQ_EN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OAM_IRQ_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COINC_IRQ_EN  = 3'd4;

  typedef struct packed {
    logic [ADV_W-1:0] dot_advance;
    logic             lcd_enable;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LINE_W-1:0] line;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
  } out_item_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_compare;
    logic              hblank_irq_enable;
    logic              vblank_stat_irq_enable;
    logic              oam_irq_enable;
    logic              coincidence_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic [DOT_W-1:0]  dot;
    logic [LINE_W-1:0] line;
    logic [MODE_W-1:0] mode;
    logic              coinc;
  } timing_state_t;

endpackage

`default_nettype wire

/* src/lcdt_stream_if.sv */
// valid/ready stream interface carrying one payload struct
`default_nettype none

interface lcdt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/lcdt_cfg_regs.sv */
// configuration register file written through a plain write port
`default_nettype none

module lcdt_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lcdt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lcdt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output lcdt_pkg::cfg_t                        cfg_o
);

  lcdt_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lcdt_pkg::REG_LINE_COMPARE:  cfg_d.line_compare = cfg_data_i[lcdt_pkg::LINE_W-1:0];
        lcdt_pkg::REG_HBLANK_IRQ_EN: cfg_d.hblank_irq_enable = cfg_data_i[0];
        lcdt_pkg::REG_VBLANK_IRQ_EN: cfg_d.vblank_stat_irq_enable = cfg_data_i[0];
        lcdt_pkg::REG_OAM_IRQ_EN:    cfg_d.oam_irq_enable = cfg_data_i[0];
        lcdt_pkg::REG_COINC_IRQ_EN:  cfg_d.coincidence_irq_enable = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* src/lcdt_step.sv */
// next dot, line, mode and interrupt requests for one advance
`default_nettype none

module lcdt_step #(
  parameter int unsigned DOTS_PER_LINE   = lcdt_pkg::DOTS_PER_LINE_DEF,
  parameter int unsigned VISIBLE_LINES   = lcdt_pkg::VISIBLE_LINES_DEF,
  parameter int unsigned LINES_PER_FRAME = lcdt_pkg::LINES_PER_FRAME_DEF
) (
  input  wire lcdt_pkg::in_item_t      item_i,
  input  wire lcdt_pkg::cfg_t          cfg_i,
  input  wire lcdt_pkg::timing_state_t state_i,
  output lcdt_pkg::timing_state_t      state_o,
  output lcdt_pkg::out_item_t          result_o
);

  localparam int unsigned SUM_W = lcdt_pkg::DOT_W + 1;
  localparam logic [SUM_W-1:0] DotsPerLine = SUM_W'(DOTS_PER_LINE);
  localparam logic [lcdt_pkg::LINE_W-1:0] LastLine = lcdt_pkg::LINE_W'(LINES_PER_FRAME - 1);
  localparam logic [lcdt_pkg::LINE_W-1:0] VisLines = lcdt_pkg::LINE_W'(VISIBLE_LINES);

  logic [SUM_W-1:0]            sum;
  logic                        wrap;
  logic [lcdt_pkg::DOT_W-1:0]  new_dot;
  logic [lcdt_pkg::LINE_W-1:0] new_line;
  logic [lcdt_pkg::MODE_W-1:0] new_mode;
  logic                        mode_changed;
  logic                        line_match;
  logic                        vb_irq;
  logic                        st_irq;

  // sum stays below twice the line length, so one subtract wraps it
  assign sum  = {1'b0, state_i.dot} + SUM_W'(item_i.dot_advance);
  assign wrap = (sum >= DotsPerLine);

  always_comb begin
    if (wrap) begin
      new_dot = lcdt_pkg::DOT_W'(sum - DotsPerLine);
    end else begin
      new_dot = sum[lcdt_pkg::DOT_W-1:0];
    end
    if (!wrap) begin
      new_line = state_i.line;
    end else if (state_i.line == LastLine) begin
      new_line = '0;
    end else begin
      new_line = state_i.line + 1'b1;
    end
  end

  always_comb begin
    if (new_line >= VisLines) begin
      new_mode = lcdt_pkg::MODE_VBLANK;
    end else if (new_dot < lcdt_pkg::OAM_END_DOT) begin
      new_mode = lcdt_pkg::MODE_OAM;
    end else if (new_dot < lcdt_pkg::XFER_END_DOT) begin
      new_mode = lcdt_pkg::MODE_XFER;
    end else begin
      new_mode = lcdt_pkg::MODE_HBLANK;
    end
  end

  assign mode_changed = (new_mode != state_i.mode);
  assign line_match   = (new_line == cfg_i.line_compare);

  always_comb begin
    vb_irq = 1'b0;
    st_irq = 1'b0;
    if (mode_changed) begin
      vb_irq = (new_mode == lcdt_pkg::MODE_VBLANK);
      st_irq = ((new_mode == lcdt_pkg::MODE_HBLANK) && cfg_i.hblank_irq_enable)
            || ((new_mode == lcdt_pkg::MODE_VBLANK) && cfg_i.vblank_stat_irq_enable)
            || ((new_mode == lcdt_pkg::MODE_OAM) && cfg_i.oam_irq_enable);
    end
    if (wrap && line_match && cfg_i.coincidence_irq_enable) begin
      st_irq = 1'b1;
    end
  end

  always_comb begin
    if (!item_i.lcd_enable) begin
      // disabled: timing clears, coincidence holds, no interrupts
      state_o.dot   = '0;
      state_o.line  = '0;
      state_o.mode  = lcdt_pkg::MODE_HBLANK;
      state_o.coinc = state_i.coinc;
      result_o.vblank_irq = 1'b0;
      result_o.stat_irq   = 1'b0;
    end else begin
      state_o.dot   = new_dot;
      state_o.line  = new_line;
      state_o.mode  = new_mode;
      state_o.coinc = wrap ? line_match : state_i.coinc;
      result_o.vblank_irq = vb_irq;
      result_o.stat_irq   = st_irq;
    end
    result_o.mode        = state_o.mode;
    result_o.line        = state_o.line;
    result_o.coincidence = state_o.coinc;
  end

endmodule

`default_nettype wire

/* src/lcd_mode_and_line_timing_core.sv */
// lcd mode and line timing core: input register, step logic, state and result register
// throughput: one transaction per cycle while the result side is ready,
// bounded by the combinational dot add and wrap
// the dot/line/mode state updates as an item moves from the input to the result register
// reset: asynchronous active low, clears timing state, config registers and both valid flags
`default_nettype none

module lcd_mode_and_line_timing_core #(
  parameter int unsigned DOTS_PER_LINE   = lcdt_pkg::DOTS_PER_LINE_DEF,
  parameter int unsigned VISIBLE_LINES   = lcdt_pkg::VISIBLE_LINES_DEF,
  parameter int unsigned LINES_PER_FRAME = lcdt_pkg::LINES_PER_FRAME_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  lcdt_stream_if.sink                          stream_i,
  lcdt_stream_if.source                        result_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [lcdt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lcdt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  lcdt_pkg::cfg_t          cfg;
  lcdt_pkg::in_item_t      in_item_q;
  logic                    in_valid_q, in_valid_d;
  lcdt_pkg::out_item_t     out_item_q, step_result;
  logic                    out_valid_q, out_valid_d;
  lcdt_pkg::timing_state_t state_q, state_d;
  logic                    advance;
  logic                    accept;

  lcdt_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lcdt_step #(
    .DOTS_PER_LINE   (DOTS_PER_LINE),
    .VISIBLE_LINES   (VISIBLE_LINES),
    .LINES_PER_FRAME (LINES_PER_FRAME)
  ) u_step (
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (step_result)
  );

  // item moves on when the result register is empty or being drained
  assign advance        = in_valid_q && (!out_valid_q || result_o.ready);
  assign stream_i.ready = !in_valid_q || advance;
  assign accept         = stream_i.valid && stream_i.ready;

  always_comb begin
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= stream_i.data;
    end
    if (advance) begin
      out_item_q <= step_result;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_item_q;

`ifndef SYNTHESIS
  a_dot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(state_q.dot) < DOTS_PER_LINE)
    else $error("dot position out of line");

  a_line_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(state_q.line) < LINES_PER_FRAME)
    else $error("line out of frame");

  a_vblank_irq_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.data.vblank_irq |-> result_o.data.mode == lcdt_pkg::MODE_VBLANK)
    else $error("vblank request outside vblank mode");

  a_state_follows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_item_q.mode == state_q.mode) && (out_item_q.line == state_q.line))
    else $error("result and timing state disagree");

  a_vblank_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (32'(result_o.data.line) >= VISIBLE_LINES)
      |-> result_o.data.mode == lcdt_pkg::MODE_VBLANK)
    else $error("non-vblank mode on a vblank line");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench for the lcd mode and line timing core
`default_nettype none

module tb_top;
  import lcdt_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 4000;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned N_PHASES        = 6;
  localparam int unsigned PHASE_ITEMS     = 215;
  localparam int unsigned MAX_REPORTS     = 10;

  // tracks dot/line/mode timing and the expected status of each accepted transaction
  class lcd_status_scoreboard;
    cfg_t            regs;
    logic [DOT_W-1:0]  dot;
    logic [LINE_W-1:0] line;
    logic [MODE_W-1:0] mode;
    logic              coinc;
    out_item_t       expected_status_q[$];
    int unsigned     n_errors;
    int unsigned     n_inputs;
    int unsigned     n_results;
    int unsigned     n_frames;
    int unsigned     n_disabled;
    int unsigned     n_vblank_irq;
    int unsigned     n_stat_irq;
    int unsigned     n_matches;

    function new();
      regs = '0;
      dot = '0;
      line = '0;
      mode = MODE_HBLANK;
      coinc = 1'b0;
      n_errors = 0;
      n_inputs = 0;
      n_results = 0;
      n_frames = 0;
      n_disabled = 0;
      n_vblank_irq = 0;
      n_stat_irq = 0;
      n_matches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LINE_COMPARE:  regs.line_compare = data;
        REG_HBLANK_IRQ_EN: regs.hblank_irq_enable = data[0];
        REG_VBLANK_IRQ_EN: regs.vblank_stat_irq_enable = data[0];
        REG_OAM_IRQ_EN:    regs.oam_irq_enable = data[0];
        REG_COINC_IRQ_EN:  regs.coincidence_irq_enable = data[0];
        default: ;
      endcase
    endfunction

    function out_item_t advance_timing(in_item_t it);
      out_item_t         r;
      int unsigned       sum;
      int unsigned       lines_gone;
      int unsigned       new_dot;
      int unsigned       new_line;
      logic [MODE_W-1:0] new_mode;
      r = '0;
      if (!it.lcd_enable) begin
        dot = '0;
        line = '0;
        mode = MODE_HBLANK;
        n_disabled++;
      end else begin
        sum        = dot + it.dot_advance;
        lines_gone = sum / DOTS_PER_LINE_DEF;
        new_dot    = sum % DOTS_PER_LINE_DEF;
        new_line   = (line + lines_gone) % LINES_PER_FRAME_DEF;
        if (new_line >= VISIBLE_LINES_DEF) begin
          new_mode = MODE_VBLANK;
        end else if (new_dot < OAM_END_DOT) begin
          new_mode = MODE_OAM;
        end else if (new_dot < XFER_END_DOT) begin
          new_mode = MODE_XFER;
        end else begin
          new_mode = MODE_HBLANK;
        end
        // pixel transfer entry never raises the status interrupt
        if (new_mode != mode) begin
          if (new_mode == MODE_VBLANK) r.vblank_irq = 1'b1;
          if ((new_mode == MODE_HBLANK && regs.hblank_irq_enable) ||
              (new_mode == MODE_VBLANK && regs.vblank_stat_irq_enable) ||
              (new_mode == MODE_OAM && regs.oam_irq_enable)) r.stat_irq = 1'b1;
        end
        if (lines_gone != 0) begin
          coinc = (new_line == regs.line_compare);
          if (coinc) n_matches++;
          if (coinc && regs.coincidence_irq_enable) r.stat_irq = 1'b1;
          if (new_line == 0) n_frames++;
        end
        dot  = new_dot[DOT_W-1:0];
        line = new_line[LINE_W-1:0];
        mode = new_mode;
      end
      r.mode = mode;
      r.line = line;
      r.coincidence = coinc;
      return r;
    endfunction

    function void note_step(in_item_t it);
      out_item_t e;
      e = advance_timing(it);
      n_inputs++;
      if (e.vblank_irq) n_vblank_irq++;
      if (e.stat_irq) n_stat_irq++;
      expected_status_q = {expected_status_q, e};
    endfunction

    function void check_status(out_item_t got);
      out_item_t e;
      n_results++;
      if (expected_status_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("error: unexpected result mode %0d line %0d coinc %0b vb %0b st %0b",
                   got.mode, got.line, got.coincidence, got.vblank_irq, got.stat_irq);
        return;
      end
      e = expected_status_q.pop_front();
      if (got.mode !== e.mode || got.line !== e.line || got.coincidence !== e.coincidence ||
          got.vblank_irq !== e.vblank_irq || got.stat_irq !== e.stat_irq) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("mismatch at result %0d:", n_results);
          $display("  expected mode %0d line %0d coinc %0b vb %0b st %0b",
                   e.mode, e.line, e.coincidence, e.vblank_irq, e.stat_irq);
          $display("  actual   mode %0d line %0d coinc %0b vb %0b st %0b",
                   got.mode, got.line, got.coincidence, got.vblank_irq, got.stat_irq);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_status_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  calm;
  int unsigned           idle_cycles;

  lcd_status_scoreboard sb;

  lcdt_stream_if #(.payload_t(in_item_t))  step_if ();
  lcdt_stream_if #(.payload_t(out_item_t)) status_if ();

  lcd_mode_and_line_timing_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stream_i   (step_if),
    .result_o   (status_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_step(int unsigned adv, bit en);
    in_item_t it;
    it.dot_advance = adv[ADV_W-1:0];
    it.lcd_enable = en;
    return it;
  endfunction

  // enabled steps with large advances get through whole frames; disables are noise
  function automatic in_item_t random_step(int unsigned disable_pct);
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      it.dot_advance = ADV_W'($urandom_range(200, 255));
    end else if (r < 88) begin
      it.dot_advance = ADV_W'($urandom_range(0, 255));
    end else begin
      it.dot_advance = ADV_W'($urandom_range(0, 3));
    end
    it.lcd_enable = ($urandom_range(0, 99) >= disable_pct);
    return it;
  endfunction

  task automatic send_step(in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      step_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    step_if.valid = 1'b1;
    step_if.data = it;
    @(posedge clk_i);
    while (!step_if.ready) @(posedge clk_i);
    sb.note_step(it);
    @(negedge clk_i);
  endtask

  // stop feeding and let every outstanding transaction come back
  task automatic drain();
    step_if.valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_regs(cfg_t c);
    logic [CFG_DATA_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0]  idxs [5];
    vals[0] = c.line_compare;
    vals[1] = CFG_DATA_W'(c.hblank_irq_enable);
    vals[2] = CFG_DATA_W'(c.vblank_stat_irq_enable);
    vals[3] = CFG_DATA_W'(c.oam_irq_enable);
    vals[4] = CFG_DATA_W'(c.coincidence_irq_enable);
    idxs[0] = REG_LINE_COMPARE;
    idxs[1] = REG_HBLANK_IRQ_EN;
    idxs[2] = REG_VBLANK_IRQ_EN;
    idxs[3] = REG_OAM_IRQ_EN;
    idxs[4] = REG_COINC_IRQ_EN;
    for (int i = 0; i < 5; i++) begin
      cfg_we = 1'b1;
      cfg_idx = idxs[i];
      cfg_data = vals[i];
      sb.set_reg(idxs[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_we = 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (status_if.valid && status_if.ready) sb.check_status(status_if.data);
    end
  end

  // result side back-pressure
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        status_if.ready = 1'b0;
        stall_left--;
      end else begin
        status_if.ready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((step_if.valid && step_if.ready) || (status_if.valid && status_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("timeout: no transaction for %0d cycles", idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    in_item_t directed_q[$];
    cfg_t     c;
    sb = new();
    rst_ni = 1'b0;
    calm = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    step_if.valid = 1'b0;
    step_if.data = '0;
    status_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed walk through the modes of a line and across line wraps with every status source enabled
    c = '{line_compare: 8'd1, default: 1'b1};
    write_regs(c);
    directed_q = {directed_q, make_step(255, 1'b0)};  // disabled, largest advance dropped
    directed_q = {directed_q, make_step(0, 1'b1)};    // oam entry
    directed_q = {directed_q, make_step(79, 1'b1)};
    directed_q = {directed_q, make_step(1, 1'b1)};    // pixel transfer, no status irq
    directed_q = {directed_q, make_step(171, 1'b1)};
    directed_q = {directed_q, make_step(1, 1'b1)};    // hblank at dot 252
    directed_q = {directed_q, make_step(203, 1'b1)};  // last dot of the line
    directed_q = {directed_q, make_step(1, 1'b1)};    // new line: oam and line match merge
    directed_q = {directed_q, make_step(255, 1'b1)};  // skips pixel transfer
    directed_q = {directed_q, make_step(200, 1'b1)};
    directed_q = {directed_q, make_step(0, 1'b1)};
    directed_q = {directed_q, make_step(255, 1'b1)};  // wrap with carry, match flag clears
    directed_q = {directed_q, make_step(0, 1'b0)};    // disable holds the match flag
    directed_q = {directed_q, make_step(255, 1'b1)};  // re-enable straight into hblank
    directed_q = {directed_q, make_step(128, 1'b1)};
    directed_q = {directed_q, make_step(73, 1'b1)};   // exact line boundary, match again
    foreach (directed_q[i]) send_step(directed_q[i]);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: c = '0;
        1: c = '{line_compare: 8'd255, default: 1'b1};
        2: c = '{line_compare: 8'd153, default: 1'b1};
        3: c = '{line_compare: 8'd144, hblank_irq_enable: 1'b0,
                 vblank_stat_irq_enable: 1'b1, oam_irq_enable: 1'b0,
                 coincidence_irq_enable: 1'b1};
        default: begin
          c.line_compare = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                                        : CFG_DATA_W'($urandom_range(0, 153));
          c.hblank_irq_enable = 1'($urandom_range(0, 1));
          c.vblank_stat_irq_enable = 1'($urandom_range(0, 1));
          c.oam_irq_enable = 1'($urandom_range(0, 1));
          c.coincidence_irq_enable = 1'($urandom_range(0, 1));
        end
      endcase
      write_regs(c);
      calm = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) send_step(random_step((p == N_PHASES - 1) ? 2 : 0));
      drain();
    end

    calm = 1'b0;
    sb.n_errors += sb.pending();
    $display("covered %0d input and %0d result transactions, %0d frame wraps, %0d disabled steps",
             sb.n_inputs, sb.n_results, sb.n_frames, sb.n_disabled);
    $display("expected %0d vblank and %0d status interrupts, %0d line matches",
             sb.n_vblank_irq, sb.n_stat_irq, sb.n_matches);
    if (sb.n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* lcd_mode_and_line_timing_core.f */
src/lcdt_pkg.sv
src/lcdt_stream_if.sv
src/lcdt_cfg_regs.sv
src/lcdt_step.sv
src/lcd_mode_and_line_timing_core.sv
sim/tb_top.sv
